@@ sv/pbd_pkg.sv @@
// ----------------------------------------------------------------------------
// pbd_pkg
// Shared constants, command and status types for the posting block decoder.
// ----------------------------------------------------------------------------
package pbd_pkg;

    localparam int BLOCK_SIZE = 128;
    localparam int LANE_COUNT = 4;
    localparam int ROWS       = BLOCK_SIZE / LANE_COUNT;
    localparam int LANE_WORDS = BLOCK_SIZE / LANE_COUNT;
    localparam int LANE_AW    = $clog2(LANE_WORDS);
    localparam int LANE_SEL_W = $clog2(LANE_COUNT);

    localparam logic [5:0] WIDTH_MAX = 6'd32;
    localparam logic [5:0] WIDTH_BAD = 6'd33;
    localparam logic [7:0] CONT_MASK = 8'h80;
    localparam logic [4:0] LAST_ROW  = 5'(ROWS - 1);
    localparam logic [2:0] VARINT_MAX_BYTES = 3'd4;

    typedef enum logic [2:0] {
        OP_NONE,
        OP_START,
        OP_VB_BYTE,
        OP_WIDTH2,
        OP_SEC_BYTE,
        OP_NEXT_SECTION,
        OP_READ,
        OP_EMIT_ROW
    } pbd_op_t;

    typedef struct packed {
        pbd_op_t op;
    } pbd_cmd_t;

    typedef struct packed {
        logic out_full;      // result register occupied
        logic start_zero;    // start beat carries count zero
        logic start_packed;  // start beat opens a bit-packed block
        logic vb_end;        // varbyte beat closes the block
        logic width_bad;     // either width byte makes header invalid
        logic row_ready;     // words for the next row are present
        logic section_done;  // all rows of the section emitted
        logic last_row;      // next row is the final one of the block
    } pbd_status_t;

endpackage

@@ sv/pbd_ctrl.sv @@
// ----------------------------------------------------------------------------
// pbd_ctrl
// Sequencer: accepts bytes and steps the packed-row drain loop.
// ----------------------------------------------------------------------------
module pbd_ctrl (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_tvalid,
    output logic                s_tready,
    input  logic                in_start,
    input  pbd_pkg::pbd_status_t status,
    output pbd_pkg::pbd_cmd_t   cmd
);
    import pbd_pkg::*;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_VB,
        ST_W2,
        ST_BP_BYTE,
        ST_CHECK,
        ST_EMIT
    } state_t;

    state_t state_reg, state_next;
    logic   take;

    assign s_tready = !status.out_full &&
                      (state_reg == ST_IDLE || state_reg == ST_VB ||
                       state_reg == ST_W2   || state_reg == ST_BP_BYTE);
    assign take = s_tvalid && s_tready;

    always_comb begin
        state_next = state_reg;
        cmd.op     = OP_NONE;
        if (take && in_start) begin
            cmd.op = OP_START;
            if (status.start_zero) begin
                state_next = ST_IDLE;
            end else if (status.start_packed) begin
                state_next = ST_W2;
            end else begin
                state_next = ST_VB;
            end
        end else begin
            unique case (state_reg)
                ST_IDLE: begin
                    // stray bytes outside a block are dropped
                end
                ST_VB: begin
                    if (take) begin
                        cmd.op = OP_VB_BYTE;
                        if (status.vb_end) state_next = ST_IDLE;
                    end
                end
                ST_W2: begin
                    if (take) begin
                        cmd.op     = OP_WIDTH2;
                        state_next = status.width_bad ? ST_IDLE : ST_CHECK;
                    end
                end
                ST_BP_BYTE: begin
                    if (take) begin
                        cmd.op     = OP_SEC_BYTE;
                        state_next = ST_CHECK;
                    end
                end
                ST_CHECK: begin
                    if (status.section_done) begin
                        cmd.op = OP_NEXT_SECTION;
                    end else if (status.row_ready) begin
                        cmd.op     = OP_READ;
                        state_next = ST_EMIT;
                    end else begin
                        state_next = ST_BP_BYTE;
                    end
                end
                ST_EMIT: begin
                    if (!status.out_full) begin
                        cmd.op     = OP_EMIT_ROW;
                        state_next = status.last_row ? ST_IDLE : ST_CHECK;
                    end
                end
                default: state_next = ST_IDLE;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

endmodule

@@ sv/pbd_datapath.sv @@
// ----------------------------------------------------------------------------
// pbd_datapath
// Varint assembly, lane word memories, row extraction and result register.
// ----------------------------------------------------------------------------
module pbd_datapath (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 cfg_we,
    input  logic                 cfg_wdata,
    input  logic [7:0]           code_byte,
    input  logic [7:0]           block_count,
    input  logic [31:0]          base_doc,
    input  pbd_pkg::pbd_cmd_t    cmd,
    output pbd_pkg::pbd_status_t status,
    input  logic                 m_tready,
    output logic                 m_tvalid,
    output logic                 value_kind,
    output logic [6:0]           first_index,
    output logic [2:0]           valid_count,
    output logic [31:0]          value_a,
    output logic [31:0]          value_b,
    output logic [31:0]          value_c,
    output logic [31:0]          value_d,
    output logic                 block_last,
    output logic                 corrupt
);
    import pbd_pkg::*;

    logic        codec_reg;
    logic [31:0] doc_reg, doc_next;
    logic [31:0] acc_reg, acc_next;
    logic [2:0]  nb_reg, nb_next;
    logic [7:0]  vd_reg, vd_next;
    logic [7:0]  tgt_reg, tgt_next;
    logic [5:0]  gw_reg, gw_next;
    logic [5:0]  fw_reg, fw_next;
    logic [9:0]  sec_reg, sec_next;
    logic [5:0]  rows_reg, rows_next;
    logic        kind_reg, kind_next;
    logic [23:0] asm_reg, asm_next;
    logic [4:0]  sh_reg, sh_next;

    logic        ov_reg, ov_next;
    logic        ok_reg, ok_next;
    logic [6:0]  oi_reg, oi_next;
    logic [2:0]  oc_reg, oc_next;
    logic [31:0] oa_reg, oa_next, ob_reg, ob_next, oc2_reg, oc2_next, od_reg, od_next;
    logic        ol_reg, ol_next;
    logic        ox_reg, ox_next;

    // lane word memories
    logic [31:0] lane_mem [LANE_COUNT][LANE_WORDS];
    logic [31:0] rd0_reg [LANE_COUNT];
    logic [31:0] rd1_reg [LANE_COUNT];
    logic                  wr_en, rd_en;
    logic [LANE_SEL_W-1:0] wr_lane;
    logic [LANE_AW-1:0]    wr_addr;
    logic [31:0]           wr_word;
    logic [LANE_AW-1:0]    rd_addr0, rd_addr1;

    // varint terms
    logic        is_start;
    logic [31:0] vb_acc, vb_doc, acc_new, vb_sum, vb_docsum;
    logic [2:0]  vb_nb;
    logic [7:0]  vb_vd, vb_tgt, vd_inc, clamp_cnt;
    logic        vb_kind, vb_cont, vb_bad, vb_done, vb_apply;
    logic [5:0]  vb_shift;

    // row terms
    logic [5:0]  bw;
    logic [9:0]  bitpos, endpos;
    logic [31:0] mask;
    logic [31:0] lv [LANE_COUNT];
    logic [63:0] pair [LANE_COUNT];
    logic [31:0] d0, d1, d2, d3;
    logic [5:0]  w2_width;

    assign is_start  = (cmd.op == OP_START);
    assign clamp_cnt = (block_count > 8'(BLOCK_SIZE)) ? 8'(BLOCK_SIZE) : block_count;
    assign vb_acc  = is_start ? 32'd0 : acc_reg;
    assign vb_nb   = is_start ? 3'd0 : nb_reg;
    assign vb_doc  = is_start ? base_doc : doc_reg;
    assign vb_vd   = is_start ? 8'd0 : vd_reg;
    assign vb_kind = is_start ? 1'b0 : kind_reg;
    assign vb_tgt  = is_start ? clamp_cnt : tgt_reg;
    assign vb_shift  = {vb_nb, 3'b000} - {3'b000, vb_nb};
    assign acc_new   = vb_acc | ({25'd0, code_byte[6:0]} << vb_shift);
    assign vb_cont   = (code_byte & CONT_MASK) != 8'd0;
    assign vb_bad    = vb_cont && (vb_nb >= VARINT_MAX_BYTES);
    assign vd_inc    = vb_vd + 8'd1;
    assign vb_done   = vd_inc >= vb_tgt;
    assign vb_sum    = acc_new + 32'd1;
    assign vb_docsum = vb_doc + vb_sum;
    assign w2_width  = (code_byte > 8'(WIDTH_MAX)) ? WIDTH_BAD : code_byte[5:0];

    assign bw     = kind_reg ? fw_reg : gw_reg;
    assign bitpos = 10'(rows_reg[4:0]) * 10'(bw);
    assign endpos = bitpos + 10'(bw) - 10'd1;
    assign mask   = ~(32'hFFFF_FFFF << bw);
    assign rd_addr0 = bitpos[9:5];
    assign rd_addr1 = bitpos[9:5] + 5'd1;

    always_comb begin
        for (int l = 0; l < LANE_COUNT; l++) begin
            pair[l] = {rd1_reg[l], rd0_reg[l]} >> sh_reg;
            lv[l]   = pair[l][31:0] & mask;
        end
    end

    assign d0 = doc_reg + lv[0] + 32'd1;
    assign d1 = d0 + lv[1] + 32'd1;
    assign d2 = d1 + lv[2] + 32'd1;
    assign d3 = d2 + lv[3] + 32'd1;

    always_comb begin
        status.out_full     = ov_reg;
        status.start_zero   = (block_count == 8'd0);
        status.start_packed = codec_reg && (block_count == 8'(BLOCK_SIZE));
        status.vb_end       = vb_bad || (!vb_cont && vb_kind && vb_done);
        status.width_bad    = (gw_reg > WIDTH_MAX) || (w2_width > WIDTH_MAX);
        status.row_ready    = (bw == 6'd0) || (sec_reg[9:4] > {1'b0, endpos[9:5]});
        status.section_done = rows_reg[5];
        status.last_row     = kind_reg && (rows_reg[4:0] == LAST_ROW);
    end

    always_comb begin
        doc_next  = doc_reg;  acc_next  = acc_reg;  nb_next   = nb_reg;
        vd_next   = vd_reg;   tgt_next  = tgt_reg;  gw_next   = gw_reg;
        fw_next   = fw_reg;   sec_next  = sec_reg;  rows_next = rows_reg;
        kind_next = kind_reg; asm_next  = asm_reg;  sh_next   = sh_reg;
        ov_next = ov_reg && !m_tready;
        ok_next = ok_reg; oi_next = oi_reg; oc_next = oc_reg; oa_next = oa_reg;
        ob_next = ob_reg; oc2_next = oc2_reg; od_next = od_reg;
        ol_next = ol_reg; ox_next = ox_reg;
        wr_en = 1'b0; rd_en = 1'b0;
        wr_lane = sec_reg[3:2];
        wr_addr = sec_reg[8:4];
        wr_word = {code_byte, asm_reg};
        vb_apply = 1'b0;

        case (cmd.op)
            OP_START: begin
                doc_next = base_doc; acc_next = 32'd0; nb_next = 3'd0;
                vd_next = 8'd0; sec_next = 10'd0; rows_next = 6'd0;
                gw_next = 6'd0; fw_next = 6'd0; kind_next = 1'b0;
                if (status.start_zero) begin
                    tgt_next = 8'd0;
                    ov_next = 1'b1; ok_next = 1'b0; oi_next = 7'd0; oc_next = 3'd0;
                    oa_next = 32'd0; ob_next = 32'd0; oc2_next = 32'd0; od_next = 32'd0;
                    ol_next = 1'b1; ox_next = 1'b0;
                end else if (status.start_packed) begin
                    tgt_next = 8'(BLOCK_SIZE);
                    gw_next  = w2_width;
                end else begin
                    tgt_next = clamp_cnt;
                    vb_apply = 1'b1;
                end
            end
            OP_VB_BYTE: vb_apply = 1'b1;
            OP_WIDTH2: begin
                fw_next = w2_width;
                if (status.width_bad) begin
                    ov_next = 1'b1; ok_next = 1'b0; oi_next = 7'd0; oc_next = 3'd0;
                    oa_next = 32'd0; ob_next = 32'd0; oc2_next = 32'd0; od_next = 32'd0;
                    ol_next = 1'b1; ox_next = 1'b1;
                end else begin
                    sec_next = 10'd0; rows_next = 6'd0; kind_next = 1'b0;
                end
            end
            OP_SEC_BYTE: begin
                case (sec_reg[1:0])
                    2'd0: asm_next[7:0]   = code_byte;
                    2'd1: asm_next[15:8]  = code_byte;
                    2'd2: asm_next[23:16] = code_byte;
                    default: wr_en = 1'b1;
                endcase
                sec_next = sec_reg + 10'd1;
            end
            OP_NEXT_SECTION: begin
                kind_next = 1'b1; rows_next = 6'd0; sec_next = 10'd0;
            end
            OP_READ: begin
                rd_en   = 1'b1;
                sh_next = bitpos[4:0];
            end
            OP_EMIT_ROW: begin
                ov_next = 1'b1; ok_next = kind_reg;
                oi_next = {rows_reg[4:0], 2'b00}; oc_next = 3'(LANE_COUNT);
                if (kind_reg) begin
                    oa_next = lv[0] + 32'd1; ob_next = lv[1] + 32'd1;
                    oc2_next = lv[2] + 32'd1; od_next = lv[3] + 32'd1;
                end else begin
                    oa_next = d0; ob_next = d1; oc2_next = d2; od_next = d3;
                    doc_next = d3;
                end
                ol_next = status.last_row; ox_next = 1'b0;
                rows_next = rows_reg + 6'd1;
            end
            default: ;
        endcase

        if (vb_apply) begin
            acc_next = acc_new;
            if (vb_cont) begin
                if (vb_bad) begin
                    ov_next = 1'b1; ok_next = vb_kind; oi_next = vb_vd[6:0]; oc_next = 3'd0;
                    oa_next = 32'd0; ob_next = 32'd0; oc2_next = 32'd0; od_next = 32'd0;
                    ol_next = 1'b1; ox_next = 1'b1;
                end else begin
                    nb_next = vb_nb + 3'd1;
                end
            end else begin
                acc_next = 32'd0; nb_next = 3'd0;
                ov_next = 1'b1; ok_next = vb_kind; oi_next = vb_vd[6:0]; oc_next = 3'd1;
                ob_next = 32'd0; oc2_next = 32'd0; od_next = 32'd0; ox_next = 1'b0;
                if (!vb_kind) begin
                    doc_next = vb_docsum; oa_next = vb_docsum; ol_next = 1'b0;
                    if (vb_done) begin
                        kind_next = 1'b1; vd_next = 8'd0;
                    end else begin
                        vd_next = vd_inc;
                    end
                end else begin
                    oa_next = vb_sum; ol_next = vb_done; vd_next = vd_inc;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            lane_mem[wr_lane][wr_addr] <= wr_word;
        end
        if (rd_en) begin
            for (int l = 0; l < LANE_COUNT; l++) begin
                rd0_reg[l] <= lane_mem[l][rd_addr0];
                rd1_reg[l] <= lane_mem[l][rd_addr1];
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            codec_reg <= 1'b0; doc_reg <= 32'd0; acc_reg <= 32'd0; nb_reg <= 3'd0;
            vd_reg <= 8'd0; tgt_reg <= 8'd0; gw_reg <= 6'd0; fw_reg <= 6'd0;
            sec_reg <= 10'd0; rows_reg <= 6'd0; kind_reg <= 1'b0; ov_reg <= 1'b0;
        end else begin
            if (cfg_we) codec_reg <= cfg_wdata;
            doc_reg <= doc_next; acc_reg <= acc_next; nb_reg <= nb_next;
            vd_reg <= vd_next; tgt_reg <= tgt_next; gw_reg <= gw_next; fw_reg <= fw_next;
            sec_reg <= sec_next; rows_reg <= rows_next; kind_reg <= kind_next;
            ov_reg <= ov_next;
        end
    end

    always_ff @(posedge aclk) begin
        asm_reg <= asm_next; sh_reg <= sh_next;
        ok_reg <= ok_next; oi_reg <= oi_next; oc_reg <= oc_next;
        oa_reg <= oa_next; ob_reg <= ob_next; oc2_reg <= oc2_next; od_reg <= od_next;
        ol_reg <= ol_next; ox_reg <= ox_next;
    end

    assign m_tvalid    = ov_reg;
    assign value_kind  = ok_reg;
    assign first_index = oi_reg;
    assign valid_count = oc_reg;
    assign value_a     = oa_reg;
    assign value_b     = ob_reg;
    assign value_c     = oc2_reg;
    assign value_d     = od_reg;
    assign block_last  = ol_reg;
    assign corrupt     = ox_reg;

endmodule

@@ sv/posting_block_decoder_core.sv @@
// A varbyte result is in the output register in the cycle after its byte beat is taken.
// Flow: a continuation or dropped byte leaves the result register free for the next beat; a byte
//   that completes a value fills it, and the next beat waits for the single result register to
//   drain. A packed byte is taken, then the row check runs; each packed row is a check with lane
//   memory read, then extract and emit; a section switch adds one more check.
// Reset: synchronous, active low; clears sequencer, codec mode and block state, not lanes.
// ----------------------------------------------------------------------------
// posting_block_decoder_core
// Posting block decoder: varbyte and four-lane 128-value bit-packed gap and
// frequency streams into rows of document ids and term frequencies.
// ----------------------------------------------------------------------------
module posting_block_decoder_core (
    input  logic         aclk,
    input  logic         aresetn,
    // configuration: codec mode, 0 varbyte, 1 bit packed
    input  logic         cfg_we,
    input  logic         cfg_wdata,
    // byte stream in
    input  logic         s_tvalid,
    output logic         s_tready,
    input  logic [47:0]  s_tdata,   // [7:0] code_byte, [15:8] block_count, [47:16] base_doc
    input  logic [0:0]   s_tuser,   // [0] block_start
    // result stream out
    output logic         m_tvalid,
    input  logic         m_tready,
    output logic [143:0] m_tdata,   // [6:0] first_index, [9:7] valid_count, [41:10] value_a,
                                    // [73:42] value_b, [105:74] value_c, [137:106] value_d
    output logic [1:0]   m_tuser,   // [0] value_kind, [1] corrupt
    output logic         m_tlast    // block_last
);
    import pbd_pkg::*;

    pbd_cmd_t    cmd;
    pbd_status_t status;

    logic        value_kind, block_last, corrupt;
    logic [6:0]  first_index;
    logic [2:0]  valid_count;
    logic [31:0] value_a, value_b, value_c, value_d;

    // sequencer: owns the input handshake and the packed-row drain loop
    pbd_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .in_start (s_tuser[0]),
        .status   (status),
        .cmd      (cmd)
    );

    // datapath: varint accumulate, lane memories, row extraction, result register
    pbd_datapath u_dp (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cfg_we      (cfg_we),
        .cfg_wdata   (cfg_wdata),
        .code_byte   (s_tdata[7:0]),
        .block_count (s_tdata[15:8]),
        .base_doc    (s_tdata[47:16]),
        .cmd         (cmd),
        .status      (status),
        .m_tready    (m_tready),
        .m_tvalid    (m_tvalid),
        .value_kind  (value_kind),
        .first_index (first_index),
        .valid_count (valid_count),
        .value_a     (value_a),
        .value_b     (value_b),
        .value_c     (value_c),
        .value_d     (value_d),
        .block_last  (block_last),
        .corrupt     (corrupt)
    );

    // pack result beat, zero filled to whole bytes
    assign m_tdata = {6'd0, value_d, value_c, value_b, value_a, valid_count, first_index};
    assign m_tuser = {corrupt, value_kind};
    assign m_tlast = block_last;

endmodule

@@ tb/tb_posting_block_decoder_core.sv @@
// ----------------------------------------------------------------------------
// tb_posting_block_decoder_core
// Self-checking bench for the posting block decoder: byte beats go in over the
// slave stream, every beat is fed to a behavioral decoder in the bench, and
// each result beat is matched field by field against the oldest prediction.
// ----------------------------------------------------------------------------
module tb_posting_block_decoder_core;
    timeunit 1ns;
    timeprecision 1ps;

    import pbd_pkg::*;

    localparam int CYCLE_LIMIT = 400000;
    localparam bit CODEC_VARBYTE = 1'b0;
    localparam bit CODEC_PACKED  = 1'b1;

    // decoder sequencing, mirrors the block's idea of where it is in a block
    typedef enum {DEC_IDLE, DEC_VB_GAP, DEC_VB_FREQ, DEC_WIDTH2, DEC_BP_GAP, DEC_BP_FREQ}
        dec_phase_t;
    typedef enum bit {ROW_BEAT, ROW_CFG} row_kind_t;

    typedef struct {
        bit        kind;
        bit [6:0]  first;
        bit [2:0]  nval;
        bit [31:0] v [4];
        bit        last;
        bit        bad;
    } post_row_t;

    typedef struct {
        row_kind_t rk;
        bit [7:0]  b;
        bit        st;
        bit [7:0]  cnt;
        bit [31:0] prev;
        bit        typed;   // expectation given by hand
        post_row_t want;
    } stim_row_t;

    logic         aclk = 1'b0;
    logic         aresetn = 1'b0;
    logic         cfg_we = 1'b0;
    logic         cfg_wdata = 1'b0;
    logic         s_tvalid = 1'b0;
    logic         s_tready;
    logic [47:0]  s_tdata = '0;    // [7:0] code_byte, [15:8] block_count, [47:16] base_doc
    logic [0:0]   s_tuser = '0;    // [0] block_start
    logic         m_tvalid;
    logic         m_tready = 1'b0;
    logic [143:0] m_tdata;         // first_index, valid_count, value_a..value_d
    logic [1:0]   m_tuser;         // [0] value_kind, [1] corrupt
    logic         m_tlast;

    posting_block_decoder_core i_dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .m_tlast   (m_tlast)
    );

    always #5 aclk = ~aclk;

    // expected result beats, oldest first
    post_row_t  posting_q[$];
    int         err_cnt = 0;
    int         beats_sent = 0;
    int         tx_idle_pct = 25;
    int         rx_idle_pct = 83;
    logic       rx_hold = 1'b0;
    int unsigned cyc = 0;

    // behavioral decoder state
    bit         codec;
    dec_phase_t dec_ph;
    bit [31:0]  doc_run, acc;
    int         acc_n, done_n, target, gw, fw, sec_n, row_n;
    bit [31:0]  lane_words [128];

    // current block for the generator
    bit         blk_first;
    bit [7:0]   blk_cnt;
    bit [31:0]  blk_prev;

    function automatic post_row_t mk_row(bit kind, int first, int nval, bit [31:0] a,
                                         bit last, bit bad);
        post_row_t r;
        r.kind = kind;
        r.first = 7'(first);
        r.nval = 3'(nval);
        r.v[0] = a;
        r.v[1] = '0;
        r.v[2] = '0;
        r.v[3] = '0;
        r.last = last;
        r.bad = bad;
        return r;
    endfunction

    // emit every packed row whose words are present; zero width needs none
    task automatic drain_rows();
        int bw, need, bitpos, k, sh;
        bit [31:0] mask, val;
        post_row_t r;
        while (dec_ph == DEC_BP_GAP || dec_ph == DEC_BP_FREQ) begin
            bw = (dec_ph == DEC_BP_GAP) ? gw : fw;
            if (row_n < 32) begin
                need = (bw == 0) ? 0 : ((((row_n * bw + bw - 1) >> 5) + 1) * 16);
                if (sec_n < need) break;
                bitpos = row_n * bw;
                k = bitpos >> 5;
                sh = bitpos & 31;
                mask = (bw >= 32) ? 32'hFFFF_FFFF : ((32'd1 << bw) - 32'd1);
                for (int lane = 0; lane < 4; lane++) begin
                    val = '0;
                    if (bw != 0) begin
                        val = lane_words[(k * 4 + lane) & 127] >> sh;
                        if (sh + bw > 32)
                            val |= lane_words[((k + 1) * 4 + lane) & 127] << (32 - sh);
                        val &= mask;
                    end
                    if (dec_ph == DEC_BP_GAP) begin
                        doc_run += val + 32'd1;
                        r.v[lane] = doc_run;
                    end else begin
                        r.v[lane] = val + 32'd1;
                    end
                end
                r.kind = (dec_ph == DEC_BP_FREQ);
                r.first = 7'(row_n * 4);
                r.nval = 3'd4;
                r.last = (dec_ph == DEC_BP_FREQ && row_n == 31);
                r.bad = 1'b0;
                posting_q = {posting_q, r};
                row_n++;
                if (r.last) dec_ph = DEC_IDLE;
            end else begin
                dec_ph = DEC_BP_FREQ;
                row_n = 0;
                sec_n = 0;
            end
        end
    endtask

    task automatic varbyte_step(bit [7:0] b);
        bit kind;
        int shift;
        bit last;
        bit [31:0] val;
        kind = (dec_ph == DEC_VB_FREQ);
        shift = 7 * acc_n;
        if (shift < 32) acc |= {25'd0, b[6:0]} << shift;
        if (b[7]) begin
            if (acc_n >= 4) begin
                // overlong varint aborts the block
                posting_q = {posting_q, mk_row(kind, done_n, 0, '0, 1'b1, 1'b1)};
                dec_ph = DEC_IDLE;
                return;
            end
            acc_n++;
            return;
        end
        if (!kind) begin
            doc_run += acc + 32'd1;
            val = doc_run;
        end else begin
            val = acc + 32'd1;
        end
        acc = '0;
        acc_n = 0;
        done_n++;
        if (!kind) begin
            posting_q = {posting_q, mk_row(1'b0, done_n - 1, 1, val, 1'b0, 1'b0)};
            if (done_n >= target) begin
                dec_ph = DEC_VB_FREQ;
                done_n = 0;
            end
        end else begin
            last = (done_n >= target);
            posting_q = {posting_q, mk_row(1'b1, done_n - 1, 1, val, last, 1'b0)};
            if (last) dec_ph = DEC_IDLE;
        end
    endtask

    task automatic decode_beat(bit [7:0] b, bit st, bit [7:0] cnt, bit [31:0] prev);
        int wi, bp;
        if (st) begin
            doc_run = prev;
            acc = '0;
            acc_n = 0;
            done_n = 0;
            sec_n = 0;
            row_n = 0;
            gw = 0;
            fw = 0;
            if (cnt == 0) begin
                dec_ph = DEC_IDLE;
                posting_q = {posting_q, mk_row(1'b0, 0, 0, '0, 1'b1, 1'b0)};
            end else if (codec == CODEC_PACKED && cnt == 8'(BLOCK_SIZE)) begin
                gw = (b > 32) ? 33 : b;
                dec_ph = DEC_WIDTH2;
            end else begin
                target = (cnt > 8'(BLOCK_SIZE)) ? BLOCK_SIZE : cnt;
                dec_ph = DEC_VB_GAP;
                varbyte_step(b);
            end
            return;
        end
        case (dec_ph)
            DEC_VB_GAP, DEC_VB_FREQ: begin
                varbyte_step(b);
            end
            DEC_WIDTH2: begin
                fw = (b > 32) ? 33 : b;
                if (gw > 32 || fw > 32) begin
                    posting_q = {posting_q, mk_row(1'b0, 0, 0, '0, 1'b1, 1'b1)};
                    dec_ph = DEC_IDLE;
                end else begin
                    dec_ph = DEC_BP_GAP;
                    sec_n = 0;
                    row_n = 0;
                    drain_rows();
                end
            end
            DEC_BP_GAP, DEC_BP_FREQ: begin
                wi = (sec_n >> 2) & 127;
                bp = sec_n & 3;
                if (bp == 0) lane_words[wi] = {24'd0, b};
                else lane_words[wi] |= {24'd0, b} << (8 * bp);
                sec_n = (sec_n + 1) & 'h3FF;
                drain_rows();
            end
            default: ;
        endcase
    endtask

    // offer one beat, hold it until taken, then predict
    task automatic put_beat(bit [7:0] b, bit st, bit [7:0] cnt, bit [31:0] prev);
        while ($urandom_range(99) < tx_idle_pct) begin
            s_tvalid <= 1'b0;
            @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata <= {prev, cnt, b};
        s_tuser <= st;
        do @(posedge aclk); while (!s_tready);
        decode_beat(b, st, cnt, prev);
        beats_sent++;
    endtask

    // drop valid and let the decoder go quiet
    task automatic settle();
        s_tvalid <= 1'b0;
        while (posting_q.size() != 0) @(posedge aclk);
        repeat (20) @(posedge aclk);
    endtask

    task automatic write_codec(bit mode);
        settle();
        cfg_we <= 1'b1;
        cfg_wdata <= mode;
        @(posedge aclk);
        codec = mode;
        cfg_we <= 1'b0;
    endtask

    task automatic put_blk(bit [7:0] b);
        put_beat(b, blk_first, blk_cnt, blk_prev);
        blk_first = 1'b0;
    endtask

    task automatic put_varint();
        int n;
        n = ($urandom_range(3) == 0) ? $urandom_range(2, 5) : 1;
        for (int i = 0; i < n - 1; i++) put_blk(8'h80 | 8'($urandom_range(127)));
        put_blk(8'($urandom_range(127)));
    endtask

    function automatic int pick_width();
        int p;
        p = $urandom_range(99);
        if (p < 12) return 0;
        if (p < 17) return $urandom_range(33, 255);
        return $urandom_range(1, 6);
    endfunction

    // one block of mostly well-formed bytes, sometimes broken or cut short;
    // budget bounds the beats spent, a block that runs past it is left unfinished
    task automatic gen_block(int gw_force, int fw_force, int budget);
        int p, nvals, bw1, bw2, nbytes, base;
        base = beats_sent;
        p = $urandom_range(99);
        if (p < 6 && dec_ph == DEC_IDLE) begin
            put_beat(8'($urandom), 1'b0, 8'($urandom), $urandom);   // stray byte
            return;
        end
        blk_first = 1'b1;
        blk_prev = $urandom;
        if (codec == CODEC_PACKED && (p < 65 || gw_force >= 0)) begin
            blk_cnt = 8'(BLOCK_SIZE);
            bw1 = (gw_force >= 0) ? gw_force : pick_width();
            bw2 = (fw_force >= 0) ? fw_force : pick_width();
            put_blk(8'(bw1));
            put_blk(8'(bw2));
            if (bw1 > 32 || bw2 > 32) return;
            nbytes = (bw1 + bw2) * 16;
            if ($urandom_range(19) == 0) nbytes = $urandom_range(nbytes);
            if (nbytes > budget - 2) nbytes = budget - 2;
            for (int i = 0; i < nbytes; i++) put_blk(8'($urandom));
            return;
        end
        p = $urandom_range(99);
        if (p < 4) blk_cnt = 8'd0;
        else if (p < 8) blk_cnt = 8'($urandom_range(128, 255));
        else blk_cnt = 8'($urandom_range(1, 12));
        if (blk_cnt == 0) begin
            put_blk(8'($urandom));
            return;
        end
        nvals = 2 * ((blk_cnt > 8'd128) ? 128 : blk_cnt);
        for (int i = 0; i < nvals; i++) begin
            if (beats_sent - base >= budget) return;
            p = $urandom_range(99);
            if (p < 2) begin
                repeat (5) put_blk(8'h80 | 8'($urandom_range(127)));   // overlong varint
                return;
            end
            if (p < 4) return;                                         // cut short
            put_varint();
        end
    endtask

    // result side: ready pattern plus one long hold-off
    always @(posedge aclk) begin
        m_tready <= !rx_hold && ($urandom_range(99) >= rx_idle_pct);
    end

    initial begin
        wait (beats_sent >= 40);
        @(posedge aclk);
        rx_hold <= 1'b1;
        repeat (400) @(posedge aclk);
        rx_hold <= 1'b0;
    end

    // result checker
    always @(posedge aclk) begin
        post_row_t w;
        if (aresetn && m_tvalid && m_tready) begin
            if (posting_q.size() == 0) begin
                $error("result beat with nothing expected");
                err_cnt++;
            end else begin
                w = posting_q.pop_front();
                if (m_tuser[0] !== w.kind) begin
                    $error("value_kind exp %0d got %0d", w.kind, m_tuser[0]);
                    err_cnt++;
                end
                if (m_tdata[6:0] !== w.first) begin
                    $error("first_index exp %0d got %0d", w.first, m_tdata[6:0]);
                    err_cnt++;
                end
                if (m_tdata[9:7] !== w.nval) begin
                    $error("valid_count exp %0d got %0d", w.nval, m_tdata[9:7]);
                    err_cnt++;
                end
                for (int i = 0; i < 4; i++) begin
                    if (m_tdata[10 + 32 * i +: 32] !== w.v[i]) begin
                        $error("value_%s exp %h got %h", i == 0 ? "a" : i == 1 ? "b" :
                               i == 2 ? "c" : "d", w.v[i], m_tdata[10 + 32 * i +: 32]);
                        err_cnt++;
                    end
                end
                if (m_tlast !== w.last) begin
                    $error("block_last exp %0d got %0d", w.last, m_tlast);
                    err_cnt++;
                end
                if (m_tuser[1] !== w.bad) begin
                    $error("corrupt exp %0d got %0d", w.bad, m_tuser[1]);
                    err_cnt++;
                end
            end
        end
    end

    // watchdog
    always @(posedge aclk) begin
        cyc <= cyc + 1;
        if (cyc == CYCLE_LIMIT) begin
            $display("posting_block_decoder_core regression: fail");
            $finish;
        end
    end

    initial begin
        stim_row_t dir_q[$];
        stim_row_t sr;
        post_row_t none;

        none = mk_row(1'b0, 0, 0, '0, 1'b0, 1'b0);
        codec = CODEC_VARBYTE;
        dec_ph = DEC_IDLE;
        doc_run = '0;
        acc = '0;
        acc_n = 0;
        done_n = 0;
        target = 0;
        gw = 0;
        fw = 0;
        sec_n = 0;
        row_n = 0;
        foreach (lane_words[i]) lane_words[i] = '0;

        // directed table: {kind, byte, start, count, prev, typed, expectation}
        dir_q = {dir_q, stim_row_t'{ROW_CFG, 8'h00, 1'b0, 8'd0, 32'd0, 1'b0, none}};
        // stray byte while idle is dropped
        dir_q = {dir_q, stim_row_t'{ROW_BEAT, 8'hA5, 1'b0, 8'd3, 32'd1, 1'b0, none}};
        // empty block
        dir_q = {dir_q, stim_row_t'{ROW_BEAT, 8'h11, 1'b1, 8'd0, 32'd5, 1'b1,
                                    mk_row(1'b0, 0, 0, '0, 1'b1, 1'b0)}};
        // doc id wraps past all ones, then largest one-byte frequency
        dir_q = {dir_q, stim_row_t'{ROW_BEAT, 8'h00, 1'b1, 8'd1, 32'hFFFF_FFFF, 1'b1,
                                    mk_row(1'b0, 0, 1, 32'd0, 1'b0, 1'b0)}};
        dir_q = {dir_q, stim_row_t'{ROW_BEAT, 8'h7F, 1'b0, 8'd0, 32'd0, 1'b1,
                                    mk_row(1'b1, 0, 1, 32'h80, 1'b1, 1'b0)}};
        // varint running past five bytes
        dir_q = {dir_q, stim_row_t'{ROW_BEAT, 8'hFF, 1'b1, 8'd1, 32'd0, 1'b0, none}};
        repeat (3)
            dir_q = {dir_q, stim_row_t'{ROW_BEAT, 8'hFF, 1'b0, 8'd0, 32'd0, 1'b0, none}};
        dir_q = {dir_q, stim_row_t'{ROW_BEAT, 8'hFF, 1'b0, 8'd0, 32'd0, 1'b1,
                                    mk_row(1'b0, 0, 0, '0, 1'b1, 1'b1)}};
        // oversize count, then a new start in the middle of the block
        dir_q = {dir_q, stim_row_t'{ROW_BEAT, 8'h81, 1'b1, 8'd255, 32'd10, 1'b0, none}};
        dir_q = {dir_q, stim_row_t'{ROW_BEAT, 8'h01, 1'b0, 8'd0, 32'd0, 1'b0, none}};
        dir_q = {dir_q, stim_row_t'{ROW_BEAT, 8'h00, 1'b1, 8'd2, 32'd0, 1'b0, none}};
        dir_q = {dir_q, stim_row_t'{ROW_BEAT, 8'h00, 1'b0, 8'd0, 32'd0, 1'b0, none}};
        dir_q = {dir_q, stim_row_t'{ROW_BEAT, 8'h05, 1'b0, 8'd0, 32'd0, 1'b0, none}};
        dir_q = {dir_q, stim_row_t'{ROW_BEAT, 8'h80, 1'b0, 8'd0, 32'd0, 1'b0, none}};
        dir_q = {dir_q, stim_row_t'{ROW_BEAT, 8'h01, 1'b0, 8'd0, 32'd0, 1'b0, none}};
        // packed mode: bad widths either side, then zero widths
        dir_q = {dir_q, stim_row_t'{ROW_CFG, 8'h01, 1'b0, 8'd0, 32'd0, 1'b0, none}};
        dir_q = {dir_q, stim_row_t'{ROW_BEAT, 8'd40, 1'b1, 8'd128, 32'd0, 1'b0, none}};
        dir_q = {dir_q, stim_row_t'{ROW_BEAT, 8'd0, 1'b0, 8'd0, 32'd0, 1'b1,
                                    mk_row(1'b0, 0, 0, '0, 1'b1, 1'b1)}};
        dir_q = {dir_q, stim_row_t'{ROW_BEAT, 8'd0, 1'b1, 8'd128, 32'd0, 1'b0, none}};
        dir_q = {dir_q, stim_row_t'{ROW_BEAT, 8'd33, 1'b0, 8'd0, 32'd0, 1'b1,
                                    mk_row(1'b0, 0, 0, '0, 1'b1, 1'b1)}};
        dir_q = {dir_q, stim_row_t'{ROW_BEAT, 8'd0, 1'b1, 8'd128, 32'd100, 1'b0, none}};
        dir_q = {dir_q, stim_row_t'{ROW_BEAT, 8'd0, 1'b0, 8'd0, 32'd0, 1'b0, none}};

        repeat (7) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        foreach (dir_q[i]) begin
            sr = dir_q[i];
            if (sr.rk == ROW_CFG) begin
                write_codec(sr.b[0]);
            end else begin
                put_beat(sr.b, sr.st, sr.cnt, sr.prev);
                if (sr.typed) begin
                    void'(posting_q.pop_back());
                    posting_q = {posting_q, sr.want};
                end
            end
        end

        // six phases: codec alternates, idling pattern moves every two
        for (int ph = 0; ph < 6; ph++) begin
            write_codec(ph[0] ? CODEC_PACKED : CODEC_VARBYTE);
            tx_idle_pct = (ph / 2 == 0) ? 25 : (ph / 2 == 1) ? 83 : 0;
            rx_idle_pct = (ph / 2 == 0) ? 83 : (ph / 2 == 1) ? 25 : 0;
            begin
                int start_cnt;
                start_cnt = beats_sent;
                // widest sections once each, a few rows deep
                if (ph == 3) gen_block(0, 32, 34);
                if (ph == 5) gen_block(32, 0, 34);
                while (beats_sent - start_cnt < 65)
                    gen_block(-1, -1, 65 - (beats_sent - start_cnt));
            end
        end

        settle();
        repeat (50) @(posedge aclk);
        if (err_cnt == 0) begin
            $display("posting_block_decoder_core regression: pass");
        end else begin
            $display("posting_block_decoder_core regression: fail");
        end
        $finish;
    end

endmodule

@@ files.f @@
sv/pbd_pkg.sv
sv/pbd_ctrl.sv
sv/pbd_datapath.sv
sv/posting_block_decoder_core.sv
tb/tb_posting_block_decoder_core.sv
